// ===== hw/rtl/tclr_pkg.sv =====
// shared types and codes of the text console line ring
package tclr_pkg;

  // field widths of the input and result words
  localparam int W_BYTE = 8;
  localparam int W_ROW  = 9;
  localparam int W_COL  = 7;
  localparam int W_CNT  = 10;
  localparam int W_SLOT = 9;

  // item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // terminal byte codes
  localparam logic [W_BYTE-1:0] CH_BS       = 8'h08;
  localparam logic [W_BYTE-1:0] CH_NL       = 8'h0A;
  localparam logic [W_BYTE-1:0] CH_CR       = 8'h0D;
  localparam logic [W_BYTE-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [W_BYTE-1:0] CH_DEL      = 8'h7F;

  typedef struct packed {
    logic              kind;
    logic [W_BYTE-1:0] byte_in;
    logic [W_ROW-1:0]  read_row;
    logic [W_COL-1:0]  read_col;
  } item_t;

  typedef struct packed {
    logic [W_COL-1:0]  cursor_column;
    logic [W_CNT-1:0]  lines_used;
    logic [W_SLOT-1:0] oldest_slot;
    logic [W_SLOT-1:0] current_slot;
    logic [W_COL-1:0]  current_length;
    logic              stored_char;
    logic              dropped_oldest;
    logic [W_BYTE-1:0] cell_char;
    logic              cell_in_line;
  } result_t;

endpackage

// ===== hw/rtl/text_console_line_ring_unit.sv =====
// Text console line ring: a scrollback store of LINES lines of up to
// COLUMNS-1 characters each. Every word on the item channel is either a
// terminal byte (newline, carriage return, backspace, printable) or a read of
// one stored cell by logical row and column; each yields exactly one result
// word. The unit takes one item per cycle while results are being taken. While
// an accepted item sits in the input register, the ring update and the
// registered read of the character and length stores run off it, and both
// land in the result register when it advances. A result that waits stalls
// only the input register behind it. The length of the cursor's line is kept
// in a register, so the stores need no clearing pass after reset and the
// unit is ready as soon as reset drops.
module text_console_line_ring_unit #(
  parameter int COLUMNS = 100,
  parameter int LINES   = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tclr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output tclr_pkg::result_t result
);

  logic            s1_valid;
  tclr_pkg::item_t s1_item;
  logic            adv;

  // pipeline advance: input register moves on when the result slot frees
  assign adv        = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  tclr_core #(
    .COLUMNS(COLUMNS),
    .LINES  (LINES)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .item(s1_item),
    .res (result)
  );

  // a dropped line only happens with the ring full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.dropped_oldest |-> result.lines_used == 10'(LINES))
    else $error("oldest line dropped while ring not full");

  // a stored character always leaves the cursor past column zero
  a_store_cursor: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stored_char |-> result.cursor_column != '0 &&
    result.current_length != '0)
    else $error("stored character without cursor advance");

  // reads never change the ring and never report an edit
  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.cell_in_line |-> !result.stored_char && !result.dropped_oldest)
    else $error("read word reported an edit");

  // cursor and length stay inside a line
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.cursor_column <= COLUMNS - 1 &&
    result.current_length <= COLUMNS - 1)
    else $error("cursor or line length past last column");

endmodule

// ===== hw/rtl/tclr_core.sv =====
// line ring state, character and length stores, and the result register
module tclr_core #(
  parameter int COLUMNS = 100,
  parameter int LINES   = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  tclr_pkg::item_t  item,
  output tclr_pkg::result_t res
);

  localparam int SLOT_W = $clog2(LINES);
  localparam int CNT_W  = $clog2(LINES + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CCMP_W = ($clog2(COLUMNS + 1) > tclr_pkg::W_COL) ?
                          $clog2(COLUMNS + 1) : tclr_pkg::W_COL;
  localparam int RCMP_W = (CNT_W > tclr_pkg::W_ROW) ? CNT_W : tclr_pkg::W_ROW;

  // ring state; the cursor's line length lives in a register, the store
  // only holds lengths of finished lines
  logic [SLOT_W-1:0] head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [COL_W-1:0]  cursor, cursor_next;
  logic [COL_W-1:0]  cur_len, cur_len_next;
  logic [SLOT_W-1:0] cur_slot, cur_slot_next;

  // stores
  logic [tclr_pkg::W_BYTE-1:0] chars [LINES][COLUMNS];
  logic [COL_W-1:0]            lens [LINES];
  logic [tclr_pkg::W_BYTE-1:0] char_q;
  logic [COL_W-1:0]            len_q;

  // result register
  logic [COL_W-1:0]         r_cursor;
  logic [CNT_W-1:0]         r_count;
  logic [SLOT_W-1:0]        r_head;
  logic [SLOT_W-1:0]        r_cur_slot;
  logic [COL_W-1:0]         r_len;
  logic                     r_stored;
  logic                     r_dropped;
  logic                     r_read;
  logic                     r_row_ok;
  logic                     r_col_ok;
  logic                     r_is_cur;
  logic [tclr_pkg::W_COL-1:0] r_col;

  logic [tclr_pkg::W_BYTE-1:0] b;
  logic                        do_byte, do_read;
  logic                        is_nl, is_cr, is_bs, is_pr, wrap, open;
  logic                        full, stored, dropped;
  logic [SLOT_W-1:0]           slot_inc, head_inc;
  logic [COL_W-1:0]            pcol, plen;
  logic                        char_we, len_we;
  logic [SLOT_W-1:0]           wslot;
  logic [COL_W-1:0]            wcol;
  logic                        row_ok, col_ok;
  logic [SLOT_W:0]             rsum;
  logic [SLOT_W-1:0]           rslot;
  logic [COL_W-1:0]            rcol;
  logic [COL_W-1:0]            len_sel;
  logic                        in_line;

  // byte decode
  assign b       = item.byte_in;
  assign do_byte = adv && (item.kind == tclr_pkg::KIND_BYTE);
  assign do_read = adv && (item.kind == tclr_pkg::KIND_READ);
  assign is_nl   = (b == tclr_pkg::CH_NL);
  assign is_cr   = (b == tclr_pkg::CH_CR);
  assign is_bs   = (b == tclr_pkg::CH_BS);
  assign is_pr   = (b >= tclr_pkg::CH_PRINT_LO) && (b < tclr_pkg::CH_DEL);
  assign wrap    = is_pr && (cursor >= COL_W'(COLUMNS - 1));
  assign open    = is_nl || wrap;

  // ring slot arithmetic, wrapping at the last slot
  assign full     = (count == CNT_W'(LINES));
  assign slot_inc = (cur_slot == SLOT_W'(LINES - 1)) ? '0 : SLOT_W'(cur_slot + 1'b1);
  assign head_inc = (head == SLOT_W'(LINES - 1)) ? '0 : SLOT_W'(head + 1'b1);

  // column and length a printable byte starts from
  assign pcol = open ? '0 : cursor;
  assign plen = open ? '0 : cur_len;

  // next state for a terminal byte
  always_comb begin
    head_next     = head;
    count_next    = count;
    cursor_next   = cursor;
    cur_len_next  = cur_len;
    cur_slot_next = cur_slot;
    stored        = 1'b0;
    dropped       = 1'b0;
    char_we       = 1'b0;
    len_we        = 1'b0;
    wslot         = open ? slot_inc : cur_slot;
    wcol          = pcol;
    if (do_byte) begin
      // new line, also taken before a printable byte at the last column
      if (open) begin
        len_we        = 1'b1;
        cur_slot_next = slot_inc;
        cursor_next   = '0;
        cur_len_next  = '0;
        dropped       = full;
        if (full) begin
          head_next = head_inc;
        end else begin
          count_next = CNT_W'(count + 1'b1);
        end
      end
      priority if (is_pr) begin
        char_we      = 1'b1;
        stored       = 1'b1;
        cursor_next  = COL_W'(pcol + 1'b1);
        cur_len_next = (pcol >= plen) ? COL_W'(pcol + 1'b1) : plen;
      end else if (is_cr) begin
        cursor_next = '0;
      end else if (is_bs) begin
        if (cursor != '0) begin
          cursor_next = COL_W'(cursor - 1'b1);
          // trim when the cursor lands on the last character
          if (cursor == cur_len) begin
            cur_len_next = COL_W'(cur_len - 1'b1);
          end
        end
      end else begin
        cursor_next = cursor_next;
      end
    end
  end

  // read address: logical row to physical slot
  assign row_ok = (RCMP_W'(item.read_row) < RCMP_W'(count));
  assign col_ok = (CCMP_W'(item.read_col) < CCMP_W'(COLUMNS));
  assign rsum   = {1'b0, head} + {1'b0, SLOT_W'(item.read_row)};
  assign rslot  = !row_ok ? '0 :
                  (rsum >= (SLOT_W + 1)'(LINES)) ? SLOT_W'(rsum - (SLOT_W + 1)'(LINES)) :
                  SLOT_W'(rsum);
  assign rcol   = col_ok ? COL_W'(item.read_col) : '0;

  // ring state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= CNT_W'(1);
      cursor   <= '0;
      cur_len  <= '0;
      cur_slot <= '0;
    end else begin
      head     <= head_next;
      count    <= count_next;
      cursor   <= cursor_next;
      cur_len  <= cur_len_next;
      cur_slot <= cur_slot_next;
    end
  end

  // character store
  always_ff @(posedge clk) begin
    if (char_we) begin
      chars[wslot][wcol] <= b;
    end
    if (do_read) begin
      char_q <= chars[rslot][rcol];
    end
  end

  // length store for finished lines
  always_ff @(posedge clk) begin
    if (len_we) begin
      lens[cur_slot] <= cur_len;
    end
    if (do_read) begin
      len_q <= lens[rslot];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      r_cursor   <= cursor_next;
      r_count    <= count_next;
      r_head     <= head_next;
      r_cur_slot <= cur_slot_next;
      r_len      <= cur_len_next;
      r_stored   <= stored;
      r_dropped  <= dropped;
      r_read     <= (item.kind == tclr_pkg::KIND_READ);
      r_row_ok   <= row_ok;
      r_col_ok   <= col_ok;
      r_is_cur   <= (rslot == cur_slot);
      r_col      <= item.read_col;
    end
  end

  // the cursor's line length comes from the register, others from the store
  assign len_sel = r_is_cur ? r_len : len_q;
  assign in_line = r_read && r_row_ok && r_col_ok && (CCMP_W'(r_col) < CCMP_W'(len_sel));

  // result word
  always_comb begin
    res.cursor_column  = tclr_pkg::W_COL'(r_cursor);
    res.lines_used     = tclr_pkg::W_CNT'(r_count);
    res.oldest_slot    = tclr_pkg::W_SLOT'(r_head);
    res.current_slot   = tclr_pkg::W_SLOT'(r_cur_slot);
    res.current_length = tclr_pkg::W_COL'(r_len);
    res.stored_char    = r_stored;
    res.dropped_oldest = r_dropped;
    res.cell_char      = in_line ? char_q : '0;
    res.cell_in_line   = in_line;
  end

endmodule

// ===== tb/tb_text_console_line_ring_unit.sv =====
// testbench for the text console line ring unit: directed and random words checked against a predictor
module tb_text_console_line_ring_unit;

  localparam int COLS   = 100;
  localparam int NLINES = 512;
  localparam int ITEMS  = 1450;
  localparam int LIMIT  = 400000;

  // stimulus block flavors
  typedef enum int {
    M_TEXT,
    M_LONG,
    M_STORM,
    M_READS,
    M_NOISE,
    M_EDIT
  } blk_mode_e;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  tclr_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  tclr_pkg::result_t result;

  text_console_line_ring_unit #(
    .COLUMNS(COLS),
    .LINES  (NLINES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // scrollback mirror
  logic [7:0] scr_chars [NLINES][COLS];
  int         scr_len [NLINES];
  int         scr_head;
  int         scr_count;
  int         scr_cursor;

  tclr_pkg::item_t   pend_q[$];
  tclr_pkg::result_t screen_results[$];

  int  cyc;
  int  errors;
  int  words_in;
  int  words_out;
  int  drv_acked;
  int  sink_seen;
  int  src_gap;
  int  sink_stall;
  bit  src_idle;
  bit  sink_idle;
  int  n_queued;
  int  n_reads;
  int  n_hits;
  int  n_drops;
  int  n_wraps;
  int  peak_lines;

  function automatic int slot_at(int logical);
    return (scr_head + logical) % NLINES;
  endfunction

  // start a fresh empty line, reusing the oldest slot once the ring is full
  function automatic bit open_fresh_line();
    int nxt;
    bit dropped;
    dropped = 1'b0;
    if (scr_count < NLINES) begin
      nxt = slot_at(scr_count);
      scr_count++;
    end else begin
      nxt = scr_head;
      scr_head = (scr_head + 1) % NLINES;
      dropped = 1'b1;
    end
    scr_len[nxt] = 0;
    scr_cursor = 0;
    return dropped;
  endfunction

  // apply one word to the mirror and form the result it should produce
  function automatic tclr_pkg::result_t console_apply(tclr_pkg::item_t it);
    tclr_pkg::result_t r;
    int                cur;
    int                s;
    r = '0;
    if (it.kind == tclr_pkg::KIND_BYTE) begin
      if (it.byte_in == tclr_pkg::CH_NL) begin
        r.dropped_oldest = open_fresh_line();
      end else if (it.byte_in == tclr_pkg::CH_CR) begin
        scr_cursor = 0;
      end else if (it.byte_in == tclr_pkg::CH_BS) begin
        if (scr_cursor > 0) begin
          scr_cursor--;
          cur = slot_at(scr_count - 1);
          if (scr_len[cur] > 0 && scr_cursor == scr_len[cur] - 1) scr_len[cur]--;
        end
      end else if (it.byte_in >= tclr_pkg::CH_PRINT_LO && it.byte_in < tclr_pkg::CH_DEL) begin
        // wrap before the last column
        if (scr_cursor >= COLS - 1) begin
          r.dropped_oldest = open_fresh_line();
          n_wraps++;
        end
        cur = slot_at(scr_count - 1);
        scr_chars[cur][scr_cursor] = it.byte_in;
        if (scr_cursor + 1 > scr_len[cur]) scr_len[cur] = scr_cursor + 1;
        scr_cursor++;
        r.stored_char = 1'b1;
      end
    end else if (int'(it.read_row) < scr_count) begin
      s = slot_at(int'(it.read_row));
      if (int'(it.read_col) < scr_len[s]) begin
        r.cell_char    = scr_chars[s][it.read_col];
        r.cell_in_line = 1'b1;
      end
    end
    cur = slot_at(scr_count - 1);
    r.cursor_column  = tclr_pkg::W_COL'(scr_cursor);
    r.lines_used     = tclr_pkg::W_CNT'(scr_count);
    r.oldest_slot    = tclr_pkg::W_SLOT'(scr_head);
    r.current_slot   = tclr_pkg::W_SLOT'(cur);
    r.current_length = tclr_pkg::W_COL'(scr_len[cur]);
    return r;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  // words with the unused fields filled at random
  function automatic tclr_pkg::item_t byte_word(logic [7:0] b);
    tclr_pkg::item_t it;
    it          = tclr_pkg::item_t'($urandom);
    it.read_col = tclr_pkg::W_COL'($urandom_range(COLS - 1, 0));
    it.kind     = tclr_pkg::KIND_BYTE;
    it.byte_in  = b;
    return it;
  endfunction

  function automatic tclr_pkg::item_t read_word(int row, int col);
    tclr_pkg::item_t it;
    it          = tclr_pkg::item_t'($urandom);
    it.kind     = tclr_pkg::KIND_READ;
    it.read_row = tclr_pkg::W_ROW'(row);
    it.read_col = tclr_pkg::W_COL'(col);
    return it;
  endfunction

  function automatic tclr_pkg::item_t print_word();
    return byte_word(8'($urandom_range(int'(tclr_pkg::CH_DEL) - 1,
                                       int'(tclr_pkg::CH_PRINT_LO))));
  endfunction

  // read aimed at a held line, column up to one past its end
  function automatic tclr_pkg::item_t aimed_read();
    int row;
    int col;
    row = $urandom_range(scr_count - 1, 0);
    col = $urandom_range(scr_len[slot_at(row)], 0);
    if (col > COLS - 1) col = COLS - 1;
    return read_word(row, col);
  endfunction

  task automatic queue_word(tclr_pkg::item_t it);
    while (pend_q.size() >= 2) begin
      @(posedge clk);
      #1;
    end
    pend_q.push_back(it);
    if (it.kind == tclr_pkg::KIND_READ || it.byte_in == tclr_pkg::CH_NL ||
        it.byte_in == tclr_pkg::CH_CR || it.byte_in == tclr_pkg::CH_BS ||
        (it.byte_in >= tclr_pkg::CH_PRINT_LO && it.byte_in < tclr_pkg::CH_DEL))
      n_queued++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: acceptance on both channels, prediction and comparison
  always @(posedge clk) begin : mon
    tclr_pkg::result_t want;
    cyc++;
    if (cyc > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, screen_results.size());
      $display("Regression FAIL");
      $finish;
    end else if (!rst) begin
      if (item_valid && item_ready) begin
        want = console_apply(item);
        screen_results.push_back(want);
        words_in++;
        if (item.kind == tclr_pkg::KIND_READ) n_reads++;
        if (want.cell_in_line) n_hits++;
        if (want.dropped_oldest) n_drops++;
        if (int'(want.lines_used) > peak_lines) peak_lines = int'(want.lines_used);
      end
      if (result_valid && result_ready) begin
        words_out++;
        if (screen_results.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, actual %h", $time, result);
        end else begin
          want = screen_results.pop_front();
          check_field("cursor_column", 32'(want.cursor_column), 32'(result.cursor_column));
          check_field("lines_used", 32'(want.lines_used), 32'(result.lines_used));
          check_field("oldest_slot", 32'(want.oldest_slot), 32'(result.oldest_slot));
          check_field("current_slot", 32'(want.current_slot), 32'(result.current_slot));
          check_field("current_length", 32'(want.current_length),
                      32'(result.current_length));
          check_field("stored_char", 32'(want.stored_char), 32'(result.stored_char));
          check_field("dropped_oldest", 32'(want.dropped_oldest),
                      32'(result.dropped_oldest));
          check_field("cell_char", 32'(want.cell_char), 32'(result.cell_char));
          check_field("cell_in_line", 32'(want.cell_in_line), 32'(result.cell_in_line));
        end
      end
    end
  end

  // driver: one word at a time from the pending queue, random gap after each while src_idle is set
  always @(negedge clk) begin : drv
    logic            nv;
    tclr_pkg::item_t ni;
    nv = item_valid;
    ni = item;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (nv && words_in != drv_acked) begin
        drv_acked = words_in;
        nv        = 1'b0;
        src_gap   = src_idle ? $urandom_range(13, 0) : 0;
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pend_q.size() != 0) begin
          ni = pend_q.pop_front();
          nv = 1'b1;
        end
      end
    end
    item_valid <= nv;
    item       <= ni;
  end

  // result side: random stall after each taken word while sink_idle is set
  always @(negedge clk) begin : sink
    if (words_out != sink_seen) begin
      sink_seen  = words_out;
      sink_stall = sink_idle ? $urandom_range(13, 0) : 0;
    end
    if (sink_stall > 0) begin
      sink_stall--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  initial begin : stim
    blk_mode_e mode;
    int        base;
    int        blen;
    int        k;
    int        pick;
    bit        first;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    for (int i = 0; i < NLINES; i++) scr_len[i] = 0;
    scr_head   = 0;
    scr_count  = 1;
    scr_cursor = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty reads, print range ends, trim and overwrite, ignored bytes
    queue_word(read_word(0, 0));
    queue_word(read_word(NLINES - 1, COLS - 1));
    queue_word(byte_word(tclr_pkg::CH_PRINT_LO));
    queue_word(byte_word(tclr_pkg::CH_DEL - 8'd1));
    queue_word(byte_word(8'h41));
    queue_word(read_word(0, 0));
    queue_word(read_word(0, 2));
    queue_word(read_word(0, 3));
    queue_word(byte_word(tclr_pkg::CH_BS));
    queue_word(read_word(0, 2));
    queue_word(byte_word(tclr_pkg::CH_CR));
    queue_word(byte_word(tclr_pkg::CH_BS));
    queue_word(byte_word(8'h78));
    queue_word(byte_word(tclr_pkg::CH_BS));
    queue_word(byte_word(tclr_pkg::CH_DEL));
    queue_word(byte_word(8'hFF));
    queue_word(byte_word(8'h80));
    queue_word(byte_word(8'h00));
    queue_word(byte_word(8'h09));
    queue_word(byte_word(tclr_pkg::CH_NL));
    queue_word(read_word(1, 0));
    queue_word(read_word(0, 1));
    queue_word(byte_word(8'h7E));
    queue_word(read_word(1, 0));
    queue_word(read_word(2, 0));

    // random blocks; the first one fills much of the ring with newlines
    base  = n_queued;
    first = 1'b1;
    while (n_queued - base < ITEMS) begin
      pick = $urandom_range(11, 0);
      if (first) mode = M_STORM;
      else if (pick < 4) mode = M_TEXT;
      else if (pick < 5) mode = M_LONG;
      else if (pick < 7) mode = M_STORM;
      else if (pick < 9) mode = M_READS;
      else if (pick < 10) mode = M_NOISE;
      else mode = M_EDIT;
      case (mode)
        M_TEXT:  blen = $urandom_range(60, 20);
        M_LONG:  blen = $urandom_range(130, 100);
        M_STORM: blen = first ? 300 : $urandom_range(220, 120);
        M_READS: blen = $urandom_range(50, 20);
        M_NOISE: blen = $urandom_range(40, 15);
        default: blen = $urandom_range(50, 20);
      endcase
      first     = 1'b0;
      src_idle  = ($urandom_range(2, 0) != 0);
      sink_idle = ($urandom_range(2, 0) != 0);
      for (k = 0; k < blen; k++) begin
        pick = $urandom_range(99, 0);
        case (mode)
          M_TEXT: begin
            if (pick < 70) queue_word(print_word());
            else if (pick < 78) queue_word(byte_word(tclr_pkg::CH_NL));
            else if (pick < 84) queue_word(byte_word(tclr_pkg::CH_CR));
            else if (pick < 92) queue_word(byte_word(tclr_pkg::CH_BS));
            else queue_word(aimed_read());
          end
          M_LONG: begin
            if (pick < 95) queue_word(print_word());
            else queue_word(aimed_read());
          end
          M_STORM: begin
            if (pick < 88) queue_word(byte_word(tclr_pkg::CH_NL));
            else if (pick < 94) queue_word(print_word());
            else queue_word(aimed_read());
          end
          M_READS: begin
            if (pick < 80) queue_word(aimed_read());
            else queue_word(read_word($urandom_range(NLINES - 1, 0), $urandom_range(COLS - 1, 0)));
          end
          M_NOISE: begin
            if (pick < 60) queue_word(byte_word(8'($urandom_range(255, 0))));
            else if (pick < 80)
              queue_word(read_word($urandom_range(NLINES - 1, 0), $urandom_range(COLS - 1, 0)));
            else queue_word(print_word());
          end
          default: begin
            if (pick < 45) queue_word(print_word());
            else if (pick < 75) queue_word(byte_word(tclr_pkg::CH_BS));
            else if (pick < 90) queue_word(byte_word(tclr_pkg::CH_CR));
            else queue_word(aimed_read());
          end
        endcase
      end
    end

    // drain
    while (pend_q.size() != 0 || item_valid) @(posedge clk);
    while (screen_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d words with %0d results: %0d cell reads (%0d inside a line)",
             words_in, words_out, n_reads, n_hits);
    $display("line wraps %0d, oldest-line drops %0d, peak lines held %0d",
             n_wraps, n_drops, peak_lines);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
